// ===== hdl/sqllex_pkg.sv =====
// Shared types and constants for the SQL subset lexer.
package sqllex_pkg;

    typedef enum logic [2:0]
    {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_MINUS,
        MODE_ERROR
    } mode_t;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [3:0] KIND_EOF     = 4'd0;
    localparam logic [3:0] KIND_IDENT   = 4'd1;
    localparam logic [3:0] KIND_STRING  = 4'd2;
    localparam logic [3:0] KIND_NUMBER  = 4'd3;
    localparam logic [3:0] KIND_KW_BASE = 4'd4;
    localparam logic [3:0] KIND_STAR    = 4'd10;
    localparam logic [3:0] KIND_COMMA   = 4'd11;
    localparam logic [3:0] KIND_LPAREN  = 4'd12;
    localparam logic [3:0] KIND_RPAREN  = 4'd13;
    localparam logic [3:0] KIND_SEMI    = 4'd14;
    localparam logic [3:0] KIND_EQUAL   = 4'd15;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM      = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed
    {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [1:0]  err;
        logic [7:0]  bad;
    } result_t;

    // Results of one input transfer: one or two.
    typedef struct packed
    {
        result_t first;
        result_t second;
        logic    two;
    } rec_t;

endpackage

// ===== hdl/sqllex_front.sv =====
// Front end: byte classification, lexer state and result building.
module sqllex_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [7:0]          ch,
    input  logic                q_full,
    output logic                push,
    output sqllex_pkg::rec_t    push_rec
);

    localparam int LW = (POS_WIDTH < 16) ? POS_WIDTH : 16;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    localparam logic [2:0] FILL_LONG = 3'd7;
    localparam logic [2:0] WIN_DEPTH = 3'd6;

    localparam logic [7:0] KW_TEXT [6][6] = '{
        '{"I", "N", "S", "E", "R", "T"},
        '{"I", "N", "T", "O", 8'h00, 8'h00},
        '{"V", "A", "L", "U", "E", "S"},
        '{"S", "E", "L", "E", "C", "T"},
        '{"F", "R", "O", "M", 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00}
    };
    localparam logic [2:0] KW_LEN [6] = '{3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5};

    sqllex_pkg::mode_t       mode_reg, mode_next;
    logic [POS_WIDTH-1:0]    pos_reg, pos_next;
    logic [POS_WIDTH-1:0]    begin_reg, begin_next;
    logic [2:0]              fill_reg, fill_next;
    logic [7:0]              win_reg [6];

    logic                    win_we;
    logic [2:0]              win_idx;
    logic [7:0]              win_data;

    logic                    accept;
    logic                    is_space, is_alpha, is_digit, is_word;
    logic [7:0]              upper_ch;
    sqllex_pkg::result_t     res [2];
    logic [1:0]              n;
    logic                    do_idle;
    logic                    eof;
    logic [POS_WIDTH-1:0]    len_v;

    function automatic logic [15:0] to16(input logic [POS_WIDTH-1:0] v);
        return 16'(v[LW-1:0]);
    endfunction

    function automatic sqllex_pkg::result_t mk(input logic [3:0] kind,
                                               input logic [15:0] start,
                                               input logic [15:0] length,
                                               input logic [1:0] err,
                                               input logic [7:0] bad);
        sqllex_pkg::result_t r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.err    = err;
        r.bad    = bad;
        return r;
    endfunction

    function automatic logic [3:0] kw_kind(input logic [7:0] w [6], input logic [2:0] f);
        logic [3:0] k;
        logic       hit;
        k = sqllex_pkg::KIND_IDENT;
        for (int i = 0; i < 6; i++)
        begin
            hit = (KW_LEN[i] == f);
            for (int j = 0; j < 6; j++)
            begin
                if (3'(j) < f && w[j] != KW_TEXT[i][j])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                k = sqllex_pkg::KIND_KW_BASE + 4'(i);
            end
        end
        return k;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    assign is_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign is_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    assign is_word  = is_alpha || is_digit || (ch == CH_UNDER);
    assign upper_ch = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        fill_next  = fill_reg;
        win_we     = 1'b0;
        win_idx    = fill_reg;
        win_data   = upper_ch;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        do_idle    = 1'b0;
        eof        = 1'b1;
        len_v      = pos_reg - begin_reg;

        if (op == sqllex_pkg::OP_END)
        begin
            unique case (mode_reg)
                sqllex_pkg::MODE_IDENT:
                begin
                    res[n[0]] = mk(kw_kind(win_reg, fill_reg), to16(begin_reg), to16(len_v),
                                   sqllex_pkg::ERR_NONE, 8'h00);
                    n = n + 2'd1;
                end
                sqllex_pkg::MODE_NUMBER:
                begin
                    res[n[0]] = mk(sqllex_pkg::KIND_NUMBER, to16(begin_reg), to16(len_v),
                                   sqllex_pkg::ERR_NONE, 8'h00);
                    n = n + 2'd1;
                end
                sqllex_pkg::MODE_STRING:
                begin
                    res[n[0]] = mk(sqllex_pkg::KIND_EOF, to16(begin_reg), 16'd0,
                                   sqllex_pkg::ERR_UNTERM, 8'h00);
                    n = n + 2'd1;
                    eof = 1'b0;
                end
                sqllex_pkg::MODE_MINUS:
                begin
                    res[n[0]] = mk(sqllex_pkg::KIND_EOF, to16(begin_reg), 16'd0,
                                   sqllex_pkg::ERR_UNSUPPORTED, CH_MINUS);
                    n = n + 2'd1;
                    eof = 1'b0;
                end
                sqllex_pkg::MODE_ERROR:
                begin
                    eof = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (eof)
            begin
                res[n[0]] = mk(sqllex_pkg::KIND_EOF, to16(pos_reg), 16'd0,
                               sqllex_pkg::ERR_NONE, 8'h00);
                n = n + 2'd1;
            end
            mode_next  = sqllex_pkg::MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
            fill_next  = 3'd0;
        end
        else if (mode_reg == sqllex_pkg::MODE_ERROR)
        begin
            n = 2'd0;
        end
        else if (&pos_reg)
        begin
            mode_next = sqllex_pkg::MODE_ERROR;
            res[0] = mk(sqllex_pkg::KIND_EOF, to16(pos_reg), 16'd0,
                        sqllex_pkg::ERR_OVERFLOW, 8'h00);
            n = 2'd1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            unique case (mode_reg)
                sqllex_pkg::MODE_STRING:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        res[0] = mk(sqllex_pkg::KIND_STRING, to16(begin_reg),
                                    to16(len_v - 1'b1), sqllex_pkg::ERR_NONE, 8'h00);
                        n = 2'd1;
                        mode_next = sqllex_pkg::MODE_IDLE;
                    end
                end
                sqllex_pkg::MODE_MINUS:
                begin
                    if (is_digit)
                    begin
                        mode_next = sqllex_pkg::MODE_NUMBER;
                    end
                    else
                    begin
                        mode_next = sqllex_pkg::MODE_ERROR;
                        res[0] = mk(sqllex_pkg::KIND_EOF, to16(begin_reg), 16'd0,
                                    sqllex_pkg::ERR_UNSUPPORTED, CH_MINUS);
                        n = 2'd1;
                    end
                end
                sqllex_pkg::MODE_IDENT:
                begin
                    if (is_word)
                    begin
                        if (fill_reg < WIN_DEPTH)
                        begin
                            win_we = 1'b1;
                        end
                        if (fill_reg != FILL_LONG)
                        begin
                            fill_next = fill_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        res[0] = mk(kw_kind(win_reg, fill_reg), to16(begin_reg), to16(len_v),
                                    sqllex_pkg::ERR_NONE, 8'h00);
                        n = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                sqllex_pkg::MODE_NUMBER:
                begin
                    if (!is_digit)
                    begin
                        res[0] = mk(sqllex_pkg::KIND_NUMBER, to16(begin_reg), to16(len_v),
                                    sqllex_pkg::ERR_NONE, 8'h00);
                        n = 2'd1;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                mode_next = sqllex_pkg::MODE_IDLE;
                if (!is_space)
                begin
                    begin_next = pos_reg;
                    if (is_alpha || ch == CH_UNDER)
                    begin
                        win_we    = 1'b1;
                        win_idx   = 3'd0;
                        fill_next = 3'd1;
                        mode_next = sqllex_pkg::MODE_IDENT;
                    end
                    else if (is_digit)
                    begin
                        mode_next = sqllex_pkg::MODE_NUMBER;
                    end
                    else if (ch == CH_MINUS)
                    begin
                        mode_next = sqllex_pkg::MODE_MINUS;
                    end
                    else if (ch == CH_QUOTE)
                    begin
                        mode_next = sqllex_pkg::MODE_STRING;
                    end
                    else
                    begin
                        unique case (ch)
                            CH_STAR:   res[n[0]] = mk(sqllex_pkg::KIND_STAR, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            CH_COMMA:  res[n[0]] = mk(sqllex_pkg::KIND_COMMA, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            CH_LPAREN: res[n[0]] = mk(sqllex_pkg::KIND_LPAREN, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            CH_RPAREN: res[n[0]] = mk(sqllex_pkg::KIND_RPAREN, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            CH_SEMI:   res[n[0]] = mk(sqllex_pkg::KIND_SEMI, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            CH_EQUAL:  res[n[0]] = mk(sqllex_pkg::KIND_EQUAL, to16(pos_reg),
                                                      16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                            default:
                            begin
                                res[n[0]] = mk(sqllex_pkg::KIND_EOF, to16(pos_reg), 16'd0,
                                               sqllex_pkg::ERR_UNSUPPORTED, ch);
                                mode_next = sqllex_pkg::MODE_ERROR;
                            end
                        endcase
                        n = n + 2'd1;
                    end
                end
            end
        end
    end

    assign push            = accept && (n != 2'd0);
    assign push_rec.first  = res[0];
    assign push_rec.second = res[1];
    assign push_rec.two    = n[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sqllex_pkg::MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            fill_reg  <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && win_we)
        begin
            win_reg[win_idx] <= win_data;
        end
    end

endmodule

// ===== hdl/sqllex_fifo.sv =====
// Result queue between the front end and the output stage.
module sqllex_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sqllex_pkg::rec_t    wdata,
    input  logic                pop,
    output sqllex_pkg::rec_t    head,
    output logic                empty,
    output logic                full
);

    localparam int PW = $clog2(sqllex_pkg::QUEUE_DEPTH);
    localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(sqllex_pkg::QUEUE_DEPTH);

    sqllex_pkg::rec_t  mem_reg [sqllex_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/sqllex_back.sv =====
// Output stage: sends each queued record as one or two result transfers.
module sqllex_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sqllex_pkg::rec_t    head,
    input  logic                q_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          token_kind,
    output logic [15:0]         token_start,
    output logic [15:0]         token_length,
    output logic [1:0]          error_code,
    output logic [7:0]          bad_char,
    output logic                last_of_run
);

    logic                 sel_reg, sel_next;
    sqllex_pkg::result_t  cur;
    logic                 xfer;

    assign out_valid    = !q_empty;
    assign cur          = sel_reg ? head.second : head.first;
    assign last_of_run  = sel_reg || !head.two;
    assign token_kind   = cur.kind;
    assign token_start  = cur.start;
    assign token_length = cur.length;
    assign error_code   = cur.err;
    assign bad_char     = cur.bad;
    assign xfer         = out_valid && !out_stall;
    assign pop          = xfer && last_of_run;

    always_comb
    begin
        sel_next = sel_reg;
        if (xfer)
        begin
            sel_next = !last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== hdl/sql_subset_lexer_top.sv =====
// Top level of the SQL subset lexer: front end, result queue, output stage.
//
//  channel | handshake          | payload
//  input   | in_valid, in_stall | op, ch
//  output  | out_valid, out_stall| token_kind, token_start, token_length,
//          |                    | error_code, bad_char, last_of_run
//
// The front end takes one byte or end marker per cycle while the 4-entry queue has room.
// Each transfer that yields results writes one queue record; the output stage sends one
// result per cycle while out_stall is low; a two-result record leaves in two transfers.
// Results are registered in the queue before they reach the output.
// Reset leaves the lexer idle at position 0 with an empty queue.
// in_stall rises only when the queue is full; out_stall holds the head result in place.
module sql_subset_lexer_top #(
    parameter int POS_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         op,
    input  logic [7:0]   ch,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [3:0]   token_kind,
    output logic [15:0]  token_start,
    output logic [15:0]  token_length,
    output logic [1:0]   error_code,
    output logic [7:0]   bad_char,
    output logic         last_of_run
);

    logic              push, pop, q_empty, q_full;
    sqllex_pkg::rec_t  push_rec, head;

    sqllex_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .ch       (ch),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    sqllex_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_rec),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    sqllex_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .error_code   (error_code),
        .bad_char     (bad_char),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== hdl/sqllex_check.sv =====
// Port-level checker for the SQL subset lexer, bound to the top level.
module sqllex_check (
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_stall,
    input logic [3:0]   token_kind,
    input logic [15:0]  token_start,
    input logic [15:0]  token_length,
    input logic [1:0]   error_code,
    input logic [7:0]   bad_char,
    input logic         last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(token_kind) && $stable(token_start)
            && $stable(token_length) && $stable(error_code) && $stable(last_of_run))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != sqllex_pkg::ERR_UNSUPPORTED |-> bad_char == 8'h00)
        else $error("bad_char set without unsupported-character error");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != sqllex_pkg::ERR_NONE
            |-> token_kind == sqllex_pkg::KIND_EOF && token_length == 16'd0)
        else $error("error result carries a token");

    a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind >= sqllex_pkg::KIND_STAR
            |-> token_length == 16'd1 && error_code == sqllex_pkg::ERR_NONE)
        else $error("punctuation token with wrong length");

endmodule

bind sql_subset_lexer_top sqllex_check u_sqllex_check (.*);

// ===== bench/sql_subset_lexer_top_tb.sv =====
// Self-checking bench for the SQL subset lexer: streamed SQL text in, token transfers checked.
module sql_subset_lexer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] KIND_INSERT = sqllex_pkg::KIND_KW_BASE + 4'd0;
    localparam logic [3:0] KIND_INTO   = sqllex_pkg::KIND_KW_BASE + 4'd1;
    localparam logic [3:0] KIND_VALUES = sqllex_pkg::KIND_KW_BASE + 4'd2;
    localparam logic [3:0] KIND_SELECT = sqllex_pkg::KIND_KW_BASE + 4'd3;
    localparam logic [3:0] KIND_FROM   = sqllex_pkg::KIND_KW_BASE + 4'd4;
    localparam logic [3:0] KIND_WHERE  = sqllex_pkg::KIND_KW_BASE + 4'd5;

    localparam logic [15:0] POS_LAST = 16'hFFFF;
    localparam logic [7:0]  CH_QUOTE = 8'h27;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_UNDER = 8'h5F;
    localparam int          PHASE_ITEMS = 600;
    localparam int          LONG_HOLD = 200;

    typedef struct
    {
        logic       op;
        logic [7:0] ch;
    } src_item_t;

    typedef struct
    {
        sqllex_pkg::result_t tok;
        logic                last;
    } token_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = sqllex_pkg::OP_DATA;
    logic [7:0]  ch = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last_of_run;

    src_item_t  src_q[$];
    token_exp_t token_q[$];
    token_exp_t step_tokens[$];

    sqllex_pkg::mode_t scan_mode = sqllex_pkg::MODE_IDLE;
    logic [15:0] scan_pos = 16'd0;
    logic [15:0] tok_begin = 16'd0;
    logic [7:0]  kw_buf [6] = '{default: 8'h00};
    logic [2:0]  kw_cnt = 3'd0;

    int    send_gap_pct = 0;
    int    recv_gap_pct = 0;
    int    mismatches = 0;
    int    pushed_total = 0;
    int    tokens_seen = 0;
    int    hold_left = 0;
    string kw_words [6] = '{"INSERT", "INTO", "VALUES", "SELECT", "FROM", "WHERE"};
    string punct_chars = "*,();=";

    sql_subset_lexer_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .error_code   (error_code),
        .bad_char     (bad_char),
        .last_of_run  (last_of_run)
    );

    always #10ns clk = ~clk;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [3:0] ident_kind(input logic [15:0] len);
        logic [47:0] w;
        w = {kw_buf[0], kw_buf[1], kw_buf[2], kw_buf[3], kw_buf[4], kw_buf[5]};
        if (len > 16'd6 || len != 16'(kw_cnt))
            return sqllex_pkg::KIND_IDENT;
        case (len)
            16'd6:
            begin
                if (w == "INSERT")
                    return KIND_INSERT;
                if (w == "VALUES")
                    return KIND_VALUES;
                if (w == "SELECT")
                    return KIND_SELECT;
            end
            16'd5:
            begin
                if (w[47:8] == "WHERE")
                    return KIND_WHERE;
            end
            16'd4:
            begin
                if (w[47:16] == "INTO")
                    return KIND_INTO;
                if (w[47:16] == "FROM")
                    return KIND_FROM;
            end
            default:
            begin
            end
        endcase
        return sqllex_pkg::KIND_IDENT;
    endfunction

    task automatic emit(input logic [3:0] kind, input logic [15:0] start,
                        input logic [15:0] len, input logic [1:0] err, input logic [7:0] bad);
        token_exp_t t;
        t.tok.kind   = kind;
        t.tok.start  = start;
        t.tok.length = len;
        t.tok.err    = err;
        t.tok.bad    = bad;
        t.last       = 1'b0;
        step_tokens.push_back(t);
    endtask

    // byte seen between tokens
    task automatic start_token(input logic [7:0] c, input logic [15:0] pos);
        scan_mode = sqllex_pkg::MODE_IDLE;
        if (is_space(c))
            return;
        tok_begin = pos;
        if (is_alpha(c) || c == CH_UNDER)
        begin
            kw_buf[0] = upcase(c);
            kw_cnt = 3'd1;
            scan_mode = sqllex_pkg::MODE_IDENT;
        end
        else if (is_digit(c))
            scan_mode = sqllex_pkg::MODE_NUMBER;
        else if (c == CH_MINUS)
            scan_mode = sqllex_pkg::MODE_MINUS;
        else if (c == CH_QUOTE)
            scan_mode = sqllex_pkg::MODE_STRING;
        else
        begin
            case (c)
                "*": emit(sqllex_pkg::KIND_STAR, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                ",": emit(sqllex_pkg::KIND_COMMA, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                "(": emit(sqllex_pkg::KIND_LPAREN, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                ")": emit(sqllex_pkg::KIND_RPAREN, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                ";": emit(sqllex_pkg::KIND_SEMI, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                "=": emit(sqllex_pkg::KIND_EQUAL, pos, 16'd1, sqllex_pkg::ERR_NONE, 8'h00);
                default:
                begin
                    scan_mode = sqllex_pkg::MODE_ERROR;
                    emit(sqllex_pkg::KIND_EOF, pos, 16'd0, sqllex_pkg::ERR_UNSUPPORTED, c);
                end
            endcase
        end
    endtask

    // expected tokens for one accepted input transfer
    task automatic lex_step(input logic is_end, input logic [7:0] c);
        logic [15:0] pos;
        logic [15:0] len;
        logic        eof;
        step_tokens.delete();
        if (is_end == sqllex_pkg::OP_END)
        begin
            len = scan_pos - tok_begin;
            eof = 1'b1;
            case (scan_mode)
                sqllex_pkg::MODE_IDENT:
                    emit(ident_kind(len), tok_begin, len, sqllex_pkg::ERR_NONE, 8'h00);
                sqllex_pkg::MODE_NUMBER:
                    emit(sqllex_pkg::KIND_NUMBER, tok_begin, len, sqllex_pkg::ERR_NONE, 8'h00);
                sqllex_pkg::MODE_STRING:
                begin
                    emit(sqllex_pkg::KIND_EOF, tok_begin, 16'd0, sqllex_pkg::ERR_UNTERM, 8'h00);
                    eof = 1'b0;
                end
                sqllex_pkg::MODE_MINUS:
                begin
                    emit(sqllex_pkg::KIND_EOF, tok_begin, 16'd0, sqllex_pkg::ERR_UNSUPPORTED,
                         CH_MINUS);
                    eof = 1'b0;
                end
                sqllex_pkg::MODE_ERROR: eof = 1'b0;
                default:
                begin
                end
            endcase
            if (eof)
                emit(sqllex_pkg::KIND_EOF, scan_pos, 16'd0, sqllex_pkg::ERR_NONE, 8'h00);
            scan_mode = sqllex_pkg::MODE_IDLE;
            scan_pos  = 16'd0;
            tok_begin = 16'd0;
            kw_cnt    = 3'd0;
        end
        else if (scan_mode != sqllex_pkg::MODE_ERROR)
        begin
            if (scan_pos == POS_LAST)
            begin
                scan_mode = sqllex_pkg::MODE_ERROR;
                emit(sqllex_pkg::KIND_EOF, scan_pos, 16'd0, sqllex_pkg::ERR_OVERFLOW, 8'h00);
            end
            else
            begin
                pos = scan_pos;
                scan_pos = pos + 16'd1;
                case (scan_mode)
                    sqllex_pkg::MODE_STRING:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            emit(sqllex_pkg::KIND_STRING, tok_begin, pos - tok_begin - 16'd1,
                                 sqllex_pkg::ERR_NONE, 8'h00);
                            scan_mode = sqllex_pkg::MODE_IDLE;
                        end
                    end
                    sqllex_pkg::MODE_MINUS:
                    begin
                        if (is_digit(c))
                            scan_mode = sqllex_pkg::MODE_NUMBER;
                        else
                        begin
                            scan_mode = sqllex_pkg::MODE_ERROR;
                            emit(sqllex_pkg::KIND_EOF, tok_begin, 16'd0,
                                 sqllex_pkg::ERR_UNSUPPORTED, CH_MINUS);
                        end
                    end
                    sqllex_pkg::MODE_IDENT:
                    begin
                        if (is_word(c))
                        begin
                            if (kw_cnt < 3'd6)
                            begin
                                kw_buf[kw_cnt] = upcase(c);
                                kw_cnt = kw_cnt + 3'd1;
                            end
                        end
                        else
                        begin
                            emit(ident_kind(pos - tok_begin), tok_begin, pos - tok_begin,
                                 sqllex_pkg::ERR_NONE, 8'h00);
                            start_token(c, pos);
                        end
                    end
                    sqllex_pkg::MODE_NUMBER:
                    begin
                        if (!is_digit(c))
                        begin
                            emit(sqllex_pkg::KIND_NUMBER, tok_begin, pos - tok_begin,
                                 sqllex_pkg::ERR_NONE, 8'h00);
                            start_token(c, pos);
                        end
                    end
                    default: start_token(c, pos);
                endcase
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            token_q.push_back(step_tokens[i]);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_token();
        token_exp_t e;
        if (token_q.size() == 0)
        begin
            report_mismatch("unexpected token", 32'(token_kind), 32'd0);
            return;
        end
        e = token_q.pop_front();
        if (token_kind !== e.tok.kind)
            report_mismatch("token_kind", 32'(token_kind), 32'(e.tok.kind));
        if (token_start !== e.tok.start)
            report_mismatch("token_start", 32'(token_start), 32'(e.tok.start));
        if (token_length !== e.tok.length)
            report_mismatch("token_length", 32'(token_length), 32'(e.tok.length));
        if (error_code !== e.tok.err)
            report_mismatch("error_code", 32'(error_code), 32'(e.tok.err));
        if (bad_char !== e.tok.bad)
            report_mismatch("bad_char", 32'(bad_char), 32'(e.tok.bad));
        if (last_of_run !== e.last)
            report_mismatch("last_of_run", 32'(last_of_run), 32'(e.last));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= sqllex_pkg::OP_DATA;
            ch       <= 8'h00;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                lex_step(op, ch);
            if (src_q.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                in_valid <= 1'b1;
                op       <= src_q[0].op;
                ch       <= src_q[0].ch;
                src_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor; long hold-offs at fixed token counts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_token();
                tokens_seen++;
                if (tokens_seen == 150 || tokens_seen == 700)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_gap_pct);
            end
        end
    end

    task automatic push_item(input logic is_end, input logic [7:0] c);
        src_item_t it;
        it.op = is_end;
        it.ch = c;
        src_q.push_back(it);
        pushed_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(sqllex_pkg::OP_DATA, s[i]);
    endtask

    function automatic logic [7:0] word_char();
        int k;
        k = $urandom_range(62);
        if (k < 26)
            return 8'("A" + k);
        if (k < 52)
            return 8'("a" + k - 26);
        if (k < 62)
            return 8'("0" + k - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] space_char();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? 8'd32 : 8'(8 + k);
    endfunction

    task automatic gen_token();
        int          n;
        logic [7:0]  c;
        string       w;
        case ($urandom_range(8))
            0, 1:
            begin
                w = kw_words[$urandom_range(5)];
                n = $urandom_range(9);
                if (n == 0)
                    w = w.substr(0, w.len() - 2);
                for (int i = 0; i < w.len(); i++)
                begin
                    c = w[i];
                    if ($urandom_range(1) == 1)
                        c = c + 8'd32;
                    push_item(sqllex_pkg::OP_DATA, c);
                end
                if (n == 1)
                    push_item(sqllex_pkg::OP_DATA, word_char());
            end
            2, 3:
            begin
                c = word_char();
                while (is_digit(c))
                    c = word_char();
                push_item(sqllex_pkg::OP_DATA, c);
                repeat ($urandom_range(8))
                    push_item(sqllex_pkg::OP_DATA, word_char());
            end
            4, 5:
            begin
                if ($urandom_range(2) == 0)
                    push_item(sqllex_pkg::OP_DATA, CH_MINUS);
                repeat ($urandom_range(1, 6))
                    push_item(sqllex_pkg::OP_DATA, 8'("0" + $urandom_range(9)));
            end
            6:
            begin
                push_item(sqllex_pkg::OP_DATA, CH_QUOTE);
                repeat ($urandom_range(8))
                begin
                    c = 8'($urandom_range(255));
                    if (c == CH_QUOTE)
                        c = 8'h22;
                    push_item(sqllex_pkg::OP_DATA, c);
                end
                push_item(sqllex_pkg::OP_DATA, CH_QUOTE);
            end
            default: push_item(sqllex_pkg::OP_DATA, punct_chars[$urandom_range(5)]);
        endcase
    endtask

    task automatic gen_statement();
        repeat ($urandom_range(1, 10))
        begin
            gen_token();
            if ($urandom_range(99) < 3)
                push_item(sqllex_pkg::OP_DATA, 8'($urandom_range(255)));
            if ($urandom_range(99) < 60)
                repeat ($urandom_range(1, 2))
                    push_item(sqllex_pkg::OP_DATA, space_char());
        end
        case ($urandom_range(19))
            0:
            begin
                push_item(sqllex_pkg::OP_DATA, CH_MINUS);
                push_item(sqllex_pkg::OP_END, 8'h00);
            end
            1:
            begin
                push_item(sqllex_pkg::OP_DATA, CH_QUOTE);
                repeat ($urandom_range(3))
                    push_item(sqllex_pkg::OP_DATA, word_char());
                push_item(sqllex_pkg::OP_END, 8'($urandom_range(255)));
            end
            2, 3:
            begin
            end
            default: push_item(sqllex_pkg::OP_END, 8'($urandom_range(255)));
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (src_q.size() != 0 || in_valid || token_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int target;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_text("Select*x,'a'=-4;()");
        push_item(sqllex_pkg::OP_END, 8'h00);
        push_text("-a");
        push_item(sqllex_pkg::OP_END, 8'hFF);
        push_text("-");
        push_item(sqllex_pkg::OP_END, 8'h00);
        push_text("'q");
        push_item(sqllex_pkg::OP_END, 8'h00);
        push_text("z");
        push_item(sqllex_pkg::OP_DATA, 8'h00);
        push_item(sqllex_pkg::OP_END, 8'h00);
        push_text("9");
        push_item(sqllex_pkg::OP_DATA, 8'hFF);
        push_item(sqllex_pkg::OP_END, 8'h00);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = (ph == 0) ? 27 : (ph == 1) ? 86 : 0;
            recv_gap_pct = (ph == 0) ? 86 : (ph == 1) ? 27 : 0;
            target = pushed_total + PHASE_ITEMS;
            while (pushed_total < target)
                gen_statement();
            push_item(sqllex_pkg::OP_END, 8'h00);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("sql_subset_lexer_top verification clean");
        else
            $display("sql_subset_lexer_top verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("sql_subset_lexer_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sqllex_pkg.sv
hdl/sqllex_front.sv
hdl/sqllex_fifo.sv
hdl/sqllex_back.sv
hdl/sql_subset_lexer_top.sv
hdl/sqllex_check.sv
bench/sql_subset_lexer_top_tb.sv
